// ===== rtl/hstd_pkg.sv =====
`timescale 1ns / 1ps
// types and constants for the headset type detect debounce block
// no dependencies; imported by every module of the block

package hstd_pkg;

    // sample and register widths
    localparam int SAMPLE_BITS = 12;
    localparam int SUM_BITS    = SAMPLE_BITS + 2;
    localparam int LIMIT_BITS  = 4;
    localparam int CFG_IDX_BITS = 3;

    // class codes
    localparam logic [1:0] CLS_UNPLUGGED = 2'd0;
    localparam logic [1:0] CLS_FOUR_POLE = 2'd1;
    localparam logic [1:0] CLS_THREE_POLE = 2'd2;
    localparam logic [1:0] CLS_HOOK = 2'd3;

    // last reported value before anything has been reported
    localparam logic [2:0] LAST_NONE = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_UNPLUG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_THREE_POLE_LIMIT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FOUR_POLE_LOW    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FOUR_POLE_HIGH   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOOK_THRESHOLD   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE_LIMIT   = 3'd5;

    // register reset values
    localparam logic [SAMPLE_BITS-1:0] RST_UNPLUG_THRESHOLD = 12'd2900;
    localparam logic [SAMPLE_BITS-1:0] RST_THREE_POLE_LIMIT = 12'd500;
    localparam logic [SAMPLE_BITS-1:0] RST_FOUR_POLE_LOW    = 12'd600;
    localparam logic [SAMPLE_BITS-1:0] RST_FOUR_POLE_HIGH   = 12'd2600;
    localparam logic [SAMPLE_BITS-1:0] RST_HOOK_THRESHOLD   = 12'd410;
    localparam logic [LIMIT_BITS-1:0]  RST_DEBOUNCE_LIMIT   = 4'd3;

    // input beat
    typedef struct packed {
        logic                   samples_ready;
        logic [SAMPLE_BITS-1:0] sample_a;
        logic [SAMPLE_BITS-1:0] sample_b;
        logic [SAMPLE_BITS-1:0] sample_c;
        logic [SAMPLE_BITS-1:0] sample_d;
        logic                   hook_ready;
        logic [SAMPLE_BITS-1:0] hook_a;
        logic [SAMPLE_BITS-1:0] hook_b;
        logic [SAMPLE_BITS-1:0] hook_c;
        logic [SAMPLE_BITS-1:0] hook_d;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic       report_valid;
        logic [1:0] reported_class;
        logic       mic_switch_write;
        logic       mic_switch_level;
    } t_out_beat;

    // threshold set
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] unplug_threshold;
        logic [SAMPLE_BITS-1:0] three_pole_limit;
        logic [SAMPLE_BITS-1:0] four_pole_low;
        logic [SAMPLE_BITS-1:0] four_pole_high;
        logic [SAMPLE_BITS-1:0] hook_threshold;
    } t_thresholds;

    // classifier verdict passed to the debounce stage
    typedef struct packed {
        logic       ready;
        logic       update;
        logic [1:0] cls;
        logic       sw_write;
        logic       sw_level;
    } t_class_info;

endpackage

// ===== rtl/hstd_classify.sv =====
`timescale 1ns / 1ps
// sample averaging and band classification for one tick
// depends on hstd_pkg

module hstd_classify
    import hstd_pkg::*;
(
    input  t_in_beat    i_beat,
    input  t_thresholds i_thr,
    output t_class_info o_info
);

    logic [SUM_BITS-1:0]    det_sum;
    logic [SUM_BITS-1:0]    hook_sum;
    logic [SAMPLE_BITS-1:0] det_avg;
    logic [SAMPLE_BITS-1:0] hook_avg;

    // four-sample sums, average by dropping two bits
    assign det_sum = {2'b00, i_beat.sample_a} + {2'b00, i_beat.sample_b}
                   + {2'b00, i_beat.sample_c} + {2'b00, i_beat.sample_d};
    assign hook_sum = {2'b00, i_beat.hook_a} + {2'b00, i_beat.hook_b}
                    + {2'b00, i_beat.hook_c} + {2'b00, i_beat.hook_d};
    assign det_avg  = det_sum[SUM_BITS-1:2];
    assign hook_avg = hook_sum[SUM_BITS-1:2];

    // band tests in fixed order; a gap leaves the class alone
    always_comb begin
        o_info.ready    = i_beat.samples_ready;
        o_info.update   = 1'b0;
        o_info.cls      = CLS_UNPLUGGED;
        o_info.sw_write = 1'b0;
        o_info.sw_level = 1'b0;
        if (i_beat.samples_ready) begin
            priority if (det_avg > i_thr.unplug_threshold) begin
                o_info.update = 1'b1;
                o_info.cls    = CLS_UNPLUGGED;
            end else if (det_avg < i_thr.three_pole_limit) begin
                o_info.update   = 1'b1;
                o_info.cls      = CLS_THREE_POLE;
                o_info.sw_write = 1'b1;
            end else if (det_avg >= i_thr.four_pole_low &&
                         det_avg < i_thr.four_pole_high) begin
                o_info.update   = 1'b1;
                o_info.sw_write = 1'b1;
                o_info.sw_level = 1'b1;
                if (i_beat.hook_ready && hook_avg <= i_thr.hook_threshold) begin
                    o_info.cls = CLS_HOOK;
                end else begin
                    o_info.cls = CLS_FOUR_POLE;
                end
            end else begin
                o_info.update = 1'b0;
            end
        end
    end

endmodule

// ===== rtl/hstd_debounce.sv =====
`timescale 1ns / 1ps
// class state and debounce counter, advanced once per processed tick
// depends on hstd_pkg

module hstd_debounce
    import hstd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  t_class_info           i_info,
    input  logic [LIMIT_BITS-1:0] i_limit,
    output logic                  o_report,
    output logic [1:0]            o_class
);

    logic [1:0]            r_cur;
    logic [2:0]            r_last;
    logic [LIMIT_BITS-1:0] r_count;
    logic [1:0]            n_cur;
    logic [2:0]            n_last;
    logic [LIMIT_BITS-1:0] n_count;

    // next class, then compare with what was last reported
    always_comb begin
        n_cur    = i_info.update ? i_info.cls : r_cur;
        n_last   = r_last;
        n_count  = r_count;
        o_report = 1'b0;
        o_class  = CLS_UNPLUGGED;
        if (i_info.ready && r_last != {1'b0, n_cur}) begin
            if (r_count >= i_limit) begin
                n_last   = {1'b0, n_cur};
                n_count  = '0;
                o_report = 1'b1;
                o_class  = n_cur;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= CLS_UNPLUGGED;
            r_last  <= LAST_NONE;
            r_count <= '0;
        end else if (i_step) begin
            r_cur   <= n_cur;
            r_last  <= n_last;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/headset_type_detect_debounce_unit.sv =====
`timescale 1ns / 1ps
// top level: config registers, input and result registers, handshakes
// depends on hstd_pkg, hstd_classify, hstd_debounce

// Headset type detector with debounce.
// Input channel: one beat per poll tick (i_in_valid / o_in_stall / i_in_data),
// taken at an edge with valid high and stall low. Every beat gives exactly
// one result beat on the output channel (o_out_valid / i_out_stall /
// o_out_data), in order.
// The accepting edge loads the input register; a later edge, taken once the
// result register is empty or not stalled, carries the beat through
// classification and debounce into the result register.
// Throughput: one beat per cycle while the receiver does not stall, set by
// the single classify-and-debounce pass between the two registers.
// When the receiver stalls, the result register holds its beat and the
// input register takes one more beat before o_in_stall rises.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data at the
// clock edge; indexes past the list are ignored. Write only while idle.
// Reset (synchronous, active low) restores the threshold defaults, clears
// the class to unplugged, marks nothing reported and empties both registers.

module headset_type_detect_debounce_unit
    import hstd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_beat                i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_beat               o_out_data,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [SAMPLE_BITS-1:0]  i_cfg_data
);

    t_thresholds           r_thr;
    logic [LIMIT_BITS-1:0] r_limit;
    t_in_beat              r_in;
    logic                  r_in_valid;
    t_out_beat             r_out;
    logic                  r_out_valid;
    t_out_beat             n_out;
    t_class_info           info;
    logic                  s1_load;
    logic                  s2_fire;
    logic                  rep;
    logic [1:0]            rep_class;

    // pipeline advance
    assign s2_fire    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !s2_fire;
    assign s1_load    = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.unplug_threshold <= RST_UNPLUG_THRESHOLD;
            r_thr.three_pole_limit <= RST_THREE_POLE_LIMIT;
            r_thr.four_pole_low    <= RST_FOUR_POLE_LOW;
            r_thr.four_pole_high   <= RST_FOUR_POLE_HIGH;
            r_thr.hook_threshold   <= RST_HOOK_THRESHOLD;
            r_limit                <= RST_DEBOUNCE_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_UNPLUG_THRESHOLD: r_thr.unplug_threshold <= i_cfg_data;
                REG_THREE_POLE_LIMIT: r_thr.three_pole_limit <= i_cfg_data;
                REG_FOUR_POLE_LOW:    r_thr.four_pole_low    <= i_cfg_data;
                REG_FOUR_POLE_HIGH:   r_thr.four_pole_high   <= i_cfg_data;
                REG_HOOK_THRESHOLD:   r_thr.hook_threshold   <= i_cfg_data;
                REG_DEBOUNCE_LIMIT:   r_limit <= i_cfg_data[LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s1_load) begin
            r_in_valid <= 1'b1;
        end else if (s2_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_in <= i_in_data;
        end
    end

    hstd_classify u_classify (
        .i_beat (r_in),
        .i_thr  (r_thr),
        .o_info (info)
    );

    hstd_debounce u_debounce (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s2_fire),
        .i_info   (info),
        .i_limit  (r_limit),
        .o_report (rep),
        .o_class  (rep_class)
    );

    // result beat
    always_comb begin
        n_out.report_valid     = rep;
        n_out.reported_class   = rep_class;
        n_out.mic_switch_write = info.sw_write;
        n_out.mic_switch_level = info.sw_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // a held input beat is not lost while the result side is blocked
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !s2_fire |=> r_in_valid)
        else $error("input beat dropped while stalled");

    // a stalled result is not overwritten by a new pass
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !s2_fire)
        else $error("result register overwritten under stall");

    // pin level only with a pin write
    a_level_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.mic_switch_level |-> o_out_data.mic_switch_write)
        else $error("mic switch level without write");

    // a non-zero class appears only with a report
    a_class_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.reported_class != CLS_UNPLUGGED
        |-> o_out_data.report_valid)
        else $error("class shown without report");
`endif

endmodule
